// ===== rtl/hlps_pkg.sv =====
// shared types, constants and pattern tables for the health led pattern sequencer
`default_nettype none

package hlps_pkg;

    localparam int PHASE_BITS   = 32;
    localparam int TIMEOUT_BITS = 16;
    localparam int CNT_W        = $clog2(PHASE_BITS);
    localparam int PERIOD_W     = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    typedef logic [2:0] t_health;
    typedef logic [3:0] t_mask;

    localparam t_health H_BOOT     = 3'd0;
    localparam t_health H_HEALTHY  = 3'd1;
    localparam t_health H_DEGRADED = 3'd2;
    localparam t_health H_UPDATING = 3'd3;
    localparam t_health H_RECOVERY = 3'd4;
    localparam t_health H_TEST     = 3'd5;
    localparam t_health H_FAULT    = 3'd6;
    localparam t_health H_SECURITY = 3'd7;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_SET_STATE  = 4'd1,
        CMD_FAULT      = 4'd2,
        CMD_SEC_FAIL   = 4'd3,
        CMD_ACK        = 4'd4,
        CMD_LED_TEST   = 4'd5,
        CMD_FAST_SWEEP = 4'd6,
        CMD_STOP       = 4'd7,
        CMD_APPLY_BOOT = 4'd8,
        CMD_EVAL_BOOT  = 4'd9
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_LED_TEST_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WDOG_MASK      = 2'd2;

    localparam logic [15:0] LED_TEST_TICKS_RST = 16'd100;
    localparam logic [15:0] SWEEP_TICKS_RST    = 16'd50;
    localparam logic [31:0] WDOG_MASK_RST      = 32'h6000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN,
        S_DONE
    } t_seq_state;

    // display priority, higher wins
    localparam logic [3:0] PRIO [8] = '{4'd2, 4'd1, 4'd4, 4'd5, 4'd6, 4'd3, 4'd7, 4'd8};

    localparam logic [3:0] FRAME_CNT [8] = '{4'd5, 4'd2, 4'd4, 4'd8, 4'd2, 4'd2, 4'd6, 4'd8};

    localparam logic [PERIOD_W-1:0] PERIOD_SLOW [8] =
        '{5'd30, 5'd10, 5'd16, 5'd16, 5'd8, 5'd4, 5'd8, 5'd10};

    localparam t_mask FRAME_MASK [8][8] = '{
        '{4'h1, 4'h3, 4'h7, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h8, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h1, 4'h3, 4'h7, 4'hF, 4'hE, 4'hC, 4'h8, 4'h0},
        '{4'h9, 4'h6, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0},
        '{4'hF, 4'h0, 4'h9, 4'h0, 4'h6, 4'h0, 4'hF, 4'h0}
    };

    localparam logic [3:0] FRAME_LEN [8][8] = '{
        '{4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd0, 4'd0, 4'd0},
        '{4'd1, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd2, 4'd2, 4'd2, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2},
        '{4'd4, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2}
    };

    // pattern period; in fast mode every frame lasts one tick
    function automatic logic [PERIOD_W-1:0] frame_period(input t_health st, input logic fast);
        logic [PERIOD_W-1:0] p;
        if (fast) begin
            p = PERIOD_W'(FRAME_CNT[st]);
        end else begin
            p = PERIOD_SLOW[st];
        end
        return p;
    endfunction

    // frame lookup for a position already reduced below the period
    function automatic t_mask frame_at(input t_health st, input logic fast,
                                       input logic [PERIOD_W-1:0] pos);
        t_mask               m;
        logic [PERIOD_W-1:0] acc;
        logic                found;
        m     = 4'h0;
        acc   = '0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(FRAME_CNT[st])) begin
                acc = acc + (fast ? PERIOD_W'(1) : PERIOD_W'(FRAME_LEN[st][i]));
                if (!found && pos < acc) begin
                    m     = FRAME_MASK[st][i];
                    found = 1'b1;
                end
            end
        end
        return m;
    endfunction

    function automatic t_health pick_shown(input logic ovr_on, input t_health ovr,
                                           input t_health auto_h);
        t_health s;
        if (ovr_on && PRIO[ovr] >= PRIO[auto_h]) begin
            s = ovr;
        end else begin
            s = auto_h;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/health_led_pattern_sequencer.sv =====
// top level of the four-led health indicator sequencer
`default_nettype none

// Four-LED health indicator. Each input item is one command (tick, set state,
// fault, security failure, acknowledge, led test, fast sweep, stop, apply or
// evaluate boot policy) and gives exactly one result item: the LED mask from
// the last tick, the state shown, the automatic state, the override flag and
// the boot verdict. A non-tick command goes from the idle state to the done
// state, which loads its result into the output register and makes the input
// ready again. A tick first passes through a divide and a finish state: the
// phase counter is reduced modulo the pattern period by a single restoring
// subtract unit, one phase bit per cycle, and the finish state then looks up
// the frame. The input is not ready while an item is at work; a finished
// result waits in the output register, and the next item may be accepted
// meanwhile. A result that finishes while the previous one still waits holds
// the sequencer until the output frees up. Configuration registers are written
// with i_cfg_we and take effect on the next item.
module health_led_pattern_sequencer
    import hlps_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,

    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [3:0]             i_cmd,
    input  wire [2:0]             i_state_code,
    input  wire [31:0]            i_reset_flags,
    input  wire                   i_fault_record_valid,
    input  wire                   i_self_tests_passed,
    input  wire                   i_security_failed,

    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [3:0]            o_led_mask,
    output logic [2:0]            o_shown_state,
    output logic [2:0]            o_auto_state,
    output logic                  o_override_active,
    output logic [2:0]            o_boot_verdict
);

    // configuration registers
    logic [15:0] r_led_test_ticks;
    logic [15:0] r_sweep_ticks;
    logic [31:0] r_wdog_mask;

    // health and override state
    t_health                 r_auto;
    t_health                 r_shown;      // last displayed state
    t_health                 r_ovr_health;
    logic [TIMEOUT_BITS-1:0] r_ticks_left;
    logic [PHASE_BITS-1:0]   r_phase;
    logic                    r_ovr_on;
    logic                    r_ovr_fast;
    t_mask                   r_held_mask;
    t_health                 r_verdict;

    // tick work: state picked, fast flag, divisor and running remainder
    t_health             r_tick_st;
    logic                r_tick_fast;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_rem;
    logic [CNT_W-1:0]    r_bit_cnt;

    t_seq_state r_state;
    t_seq_state n_state;

    logic in_acc;
    logic out_free;
    logic last_bit;

    t_health             cur_shown;
    logic                cur_fast;
    t_health             verdict;
    logic [PERIOD_W:0]   rem_shift;
    logic [PERIOD_W-1:0] rem_next;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !o_out_valid || i_out_ready;
    assign last_bit = (r_bit_cnt == '0);

    assign cur_shown = pick_shown(r_ovr_on, r_ovr_health, r_auto);
    // fast frames only apply while the override itself is on display
    assign cur_fast  = r_ovr_on && (cur_shown == r_ovr_health) && r_ovr_fast;

    // boot policy: security first, then self tests, then fault record or watchdog
    always_comb begin
        priority if (i_security_failed) begin
            verdict = H_SECURITY;
        end else if (!i_self_tests_passed) begin
            verdict = H_FAULT;
        end else if (i_fault_record_valid || ((i_reset_flags & r_wdog_mask) != '0)) begin
            verdict = H_DEGRADED;
        end else begin
            verdict = H_HEALTHY;
        end
    end

    // single restoring subtract step: bring in one phase bit, subtract if it fits
    always_comb begin
        rem_shift = {r_rem, r_phase[r_bit_cnt]};
        if (rem_shift >= {1'b0, r_period}) begin
            rem_next = PERIOD_W'(rem_shift - {1'b0, r_period});
        end else begin
            rem_next = rem_shift[PERIOD_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (t_cmd'(i_cmd) == CMD_TICK) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (last_bit) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_test_ticks <= LED_TEST_TICKS_RST;
            r_sweep_ticks    <= SWEEP_TICKS_RST;
            r_wdog_mask      <= WDOG_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LED_TEST_TICKS: r_led_test_ticks <= i_cfg_data[15:0];
                REG_SWEEP_TICKS:    r_sweep_ticks    <= i_cfg_data[15:0];
                REG_WDOG_MASK:      r_wdog_mask      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // health state, commands and the tick datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto       <= H_BOOT;
            r_shown      <= H_BOOT;
            r_ovr_health <= H_HEALTHY;
            r_ticks_left <= '0;
            r_phase      <= '0;
            r_ovr_on     <= 1'b0;
            r_ovr_fast   <= 1'b0;
            r_held_mask  <= '0;
            r_verdict    <= H_BOOT;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // only the boot policy commands report a verdict
                        r_verdict <= (i_cmd == CMD_APPLY_BOOT || i_cmd == CMD_EVAL_BOOT) ?
                                     verdict : H_BOOT;
                        unique case (i_cmd)
                            CMD_TICK: begin
                                // a change of shown state restarts the pattern
                                if (cur_shown != r_shown) begin
                                    r_shown <= cur_shown;
                                    r_phase <= '0;
                                end
                            end
                            CMD_SET_STATE: begin
                                if (PRIO[i_state_code] >= PRIO[r_auto]) begin
                                    r_auto <= i_state_code;
                                end
                            end
                            CMD_FAULT: begin
                                r_auto <= H_FAULT;
                            end
                            CMD_SEC_FAIL: begin
                                r_auto <= H_SECURITY;
                            end
                            CMD_ACK: begin
                                if (r_auto == H_DEGRADED) begin
                                    r_auto <= H_HEALTHY;
                                end
                                r_ticks_left <= '0;
                                r_ovr_on     <= 1'b0;
                                r_ovr_fast   <= 1'b0;
                                r_phase      <= '0;
                            end
                            CMD_LED_TEST: begin
                                r_ovr_health <= i_state_code;
                                r_ticks_left <= TIMEOUT_BITS'(r_led_test_ticks);
                                r_ovr_on     <= 1'b1;
                                r_ovr_fast   <= 1'b0;
                                r_phase      <= '0;
                            end
                            CMD_FAST_SWEEP: begin
                                r_ovr_health <= H_HEALTHY;
                                r_ticks_left <= TIMEOUT_BITS'(r_sweep_ticks);
                                r_ovr_on     <= 1'b1;
                                r_ovr_fast   <= 1'b1;
                                r_phase      <= '0;
                            end
                            CMD_STOP: begin
                                r_ticks_left <= '0;
                                r_ovr_on     <= 1'b0;
                                r_ovr_fast   <= 1'b0;
                                r_phase      <= '0;
                            end
                            CMD_APPLY_BOOT: begin
                                r_auto <= verdict;
                            end
                            CMD_EVAL_BOOT: begin
                                // verdict only, no state change
                            end
                            default: begin
                                // unused codes leave everything alone
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    // frame lookup on the reduced phase, then advance and time out
                    r_held_mask <= frame_at(r_tick_st, r_tick_fast, r_rem);
                    if (r_ovr_on && (r_ticks_left == TIMEOUT_BITS'(1))) begin
                        r_ticks_left <= '0;
                        r_ovr_on     <= 1'b0;
                        r_ovr_fast   <= 1'b0;
                        r_phase      <= '0;
                    end else begin
                        r_phase <= r_phase + PHASE_BITS'(1);
                        if (r_ovr_on && (r_ticks_left != '0)) begin
                            r_ticks_left <= r_ticks_left - TIMEOUT_BITS'(1);
                        end
                    end
                end
                S_DIV, S_DONE: begin
                end
            endcase
        end
    end

    // divider operands and bit counter
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_tick_st   <= cur_shown;
            r_tick_fast <= cur_fast;
            r_period    <= frame_period(cur_shown, cur_fast);
            r_rem       <= '0;
            r_bit_cnt   <= CNT_W'(PHASE_BITS - 1);
        end else if (r_state == S_DIV) begin
            r_rem     <= rem_next;
            r_bit_cnt <= r_bit_cnt - CNT_W'(1);
        end
    end

    // output register: the result waits here while the next item is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_led_mask        <= r_held_mask;
            o_shown_state     <= cur_shown;
            o_auto_state      <= r_auto;
            o_override_active <= r_ovr_on;
            o_boot_verdict    <= r_verdict;
        end
    end

endmodule

`default_nettype wire
